// ===== rtl/core/sodw_pkg.sv =====
// shared constants, types and lookup functions for the divisor-sum block
package sodw_pkg;

	localparam int IN_W          = 32;
	localparam int SUM_W         = 35;
	localparam int OUT_DATA_W    = ((2 * SUM_W + 7) / 8) * 8;
	localparam int DEF_NUM_WIDTH = 32;

	// first wheel candidate after the leading primes
	localparam logic [3:0] WHEEL_START = 4'd7;
	// index of the last leading prime
	localparam logic [1:0] LAST_PRIME_IDX = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_FOLD,
		ST_DONE
	} sodw_state_t;

	typedef enum logic [1:0] {
		MUL_TOTAL,
		MUL_PROD,
		MUL_FINAL
	} sodw_mul_op_t;

	function automatic logic [3:0] first_prime(input logic [1:0] idx);
		logic [3:0] p;
		unique case (idx)
			2'd0:    p = 4'd2;
			2'd1:    p = 4'd3;
			default: p = 4'd5;
		endcase
		return p;
	endfunction

	function automatic logic [3:0] wheel_gap(input logic [2:0] idx);
		logic [3:0] g;
		unique case (idx)
			3'd0:    g = 4'd4;
			3'd1:    g = 4'd2;
			3'd2:    g = 4'd4;
			3'd3:    g = 4'd2;
			3'd4:    g = 4'd4;
			3'd5:    g = 4'd6;
			3'd6:    g = 4'd2;
			default: g = 4'd6;
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/core/sodw_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module sodw_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rmd
);
	import sodw_pkg::*;

	localparam int CW = $clog2(W);

	logic [W-1:0]  acc_q;
	logic [W-1:0]  quot_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic          fits;

	// shifted partial remainder minus divisor; no borrow means the bit is one
	assign trial = {acc_q, quot_q[W-1]} - {1'b0, dvs_q};
	assign fits  = ~trial[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			quot_q <= dividend;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			acc_q  <= fits ? trial[W-1:0] : {acc_q[W-2:0], quot_q[W-1]};
			quot_q <= {quot_q[W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rmd  = acc_q;

endmodule

// ===== rtl/core/sodw_mul.sv =====
// bit-serial shift-and-add multiplier, product kept modulo 2^W
module sodw_mul #(
	parameter int W = 35
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] op_a,
	input  logic [W-1:0] op_b,
	output logic         done,
	output logic [W-1:0] prod
);
	import sodw_pkg::*;

	localparam int CW = $clog2(W);

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[W-2:0], 1'b0};
			b_q <= {1'b0, b_q[W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== rtl/core/sum_of_divisors_wheel.sv =====
// top level: sigma(n) and proper divisor sum by wheel trial division
// One item at a time. n is stripped of the primes 2, 3 and 5 and then of the
// candidates of a mod-30 wheel from 7, stopping once the candidate exceeds the
// quotient (k*k > cofactor); a cofactor above one left at that point is a prime
// and folds in as (1+p). Every trial takes one pass of the bit-serial divider
// (NUM_WIDTH capped at 32); each prime factor found adds one divide plus one
// serial multiply per power, the last of them closing the prime into the running
// product, and a prime cofactor left at the end adds one more multiply. The
// trials number about 4/15 of the larger of the second largest prime factor and
// the square root of the largest. n equal to zero goes straight to the done
// state with both sums zero. The result sits in an output register, so a new
// number is taken as soon as the previous result has been loaded there.
module sum_of_divisors_wheel #(
	parameter int NUM_WIDTH = sodw_pkg::DEF_NUM_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [31:0] number_in
	input  logic [sodw_pkg::IN_W-1:0]       s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [34:0] divisor_sum, [69:35] proper_divisor_sum, [71:70] zero
	output logic [sodw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import sodw_pkg::*;

	// only the low NUM_WIDTH bits of the input field take part
	localparam int N_W = (NUM_WIDTH < IN_W) ? NUM_WIDTH : IN_W;
	localparam int PAD_W = OUT_DATA_W - 2 * SUM_W;

	sodw_state_t  state_q, state_n;
	sodw_mul_op_t mul_op_q;

	// working registers of the current item
	logic [N_W-1:0]   n_q;        // the input value, kept for sigma - n
	logic [N_W-1:0]   rem_q;      // shrinking cofactor
	logic [N_W-1:0]   k_q;        // current trial divisor
	logic [1:0]       pidx_q;     // which leading prime
	logic [2:0]       gidx_q;     // wheel gap position
	logic             wheel_q;    // past the leading primes
	logic             strip_q;    // at least one factor of k taken out
	logic [SUM_W-1:0] total_q;    // 1 + k + ... + k^e so far
	logic [SUM_W-1:0] prod_q;     // running sigma

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] proper_q;
	logic             m_valid_q;

	logic [N_W-1:0]   n_in;
	logic             in_xfer;
	logic             out_load;
	logic             div_start;
	logic             div_done;
	logic [N_W-1:0]   div_quot;
	logic [N_W-1:0]   div_rmd;
	logic             mul_start;
	logic             mul_done;
	logic [SUM_W-1:0] mul_a;
	logic [SUM_W-1:0] mul_b;
	logic [SUM_W-1:0] mul_prod;
	logic             rmd_zero;
	logic             past_root;

	// next candidate divisor
	logic [N_W-1:0]   k_adv;
	logic [1:0]       pidx_adv;
	logic [2:0]       gidx_adv;
	logic             wheel_adv;

	assign n_in      = s_axis_tdata[N_W-1:0];
	assign in_xfer   = s_axis_tvalid & s_axis_tready;
	assign rmd_zero  = (div_rmd == '0);
	// k > rem / k is the same test as k*k > rem
	assign past_root = wheel_q & (k_q > div_quot);

	sodw_div #(
		.W (N_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rem_q),
		.divisor  (k_q),
		.done     (div_done),
		.quot     (div_quot),
		.rmd      (div_rmd)
	);

	sodw_mul #(
		.W (SUM_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// multiplier operands: total*k+1 while stripping, prod*total when a prime
	// closes, prod*(rem+1) for the last prime cofactor
	always_comb begin
		mul_a = prod_q;
		mul_b = {{(SUM_W - N_W){1'b0}}, rem_q} + 1'b1;
		unique case (mul_op_q)
			MUL_TOTAL: begin
				mul_a = total_q;
				mul_b = {{(SUM_W - N_W){1'b0}}, k_q};
			end
			MUL_PROD: begin
				mul_b = total_q;
			end
			MUL_FINAL: begin
				mul_b = {{(SUM_W - N_W){1'b0}}, rem_q} + 1'b1;
			end
			default: begin
				mul_b = {{(SUM_W - N_W){1'b0}}, rem_q} + 1'b1;
			end
		endcase
	end

	// step to the next candidate: 2, 3, 5, then 7 and the wheel gaps
	always_comb begin
		k_adv     = k_q;
		pidx_adv  = pidx_q;
		gidx_adv  = gidx_q;
		wheel_adv = wheel_q;
		if (!wheel_q) begin
			if (pidx_q == LAST_PRIME_IDX) begin
				k_adv     = {{(N_W - 4){1'b0}}, WHEEL_START};
				gidx_adv  = '0;
				wheel_adv = 1'b1;
			end else begin
				pidx_adv = pidx_q + 2'd1;
				k_adv    = {{(N_W - 4){1'b0}}, first_prime(pidx_q + 2'd1)};
			end
		end else begin
			k_adv    = k_q + {{(N_W - 4){1'b0}}, wheel_gap(gidx_q)};
			gidx_adv = gidx_q + 3'd1;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_n = (n_in == '0) ? ST_DONE : ST_DIV_GO;
				end
			end
			ST_DIV_GO: state_n = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					if (strip_q) begin
						state_n = ST_MUL_GO;
					end else if (past_root) begin
						state_n = ST_FOLD;
					end else begin
						state_n = ST_DIV_GO;
					end
				end
			end
			ST_MUL_GO: state_n = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (mul_done) begin
					state_n = (mul_op_q == MUL_FINAL) ? ST_DONE : ST_DIV_GO;
				end
			end
			ST_FOLD: state_n = (rem_q > {{(N_W - 1){1'b0}}, 1'b1}) ? ST_MUL_GO : ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		div_start     = (state_q == ST_DIV_GO);
		mul_start     = (state_q == ST_MUL_GO);
		out_load      = (state_q == ST_DONE) & (~m_valid_q | m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the factorisation
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					n_q     <= n_in;
					rem_q   <= n_in;
					k_q     <= {{(N_W - 4){1'b0}}, first_prime(2'd0)};
					pidx_q  <= '0;
					gidx_q  <= '0;
					wheel_q <= 1'b0;
					strip_q <= 1'b0;
					// zero input gives sigma zero
					prod_q  <= (n_in == '0) ? '0 : {{(SUM_W - 1){1'b0}}, 1'b1};
				end
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					if (strip_q) begin
						if (rmd_zero) begin
							rem_q    <= div_quot;
							mul_op_q <= MUL_TOTAL;
						end else begin
							mul_op_q <= MUL_PROD;
						end
					end else if (!past_root) begin
						if (rmd_zero) begin
							// first factor of k: total is 1 + k
							rem_q   <= div_quot;
							strip_q <= 1'b1;
							total_q <= {{(SUM_W - N_W){1'b0}}, k_q} + 1'b1;
						end else begin
							k_q     <= k_adv;
							pidx_q  <= pidx_adv;
							gidx_q  <= gidx_adv;
							wheel_q <= wheel_adv;
						end
					end
				end
			end
			ST_MUL_WAIT: begin
				if (mul_done) begin
					unique case (mul_op_q)
						MUL_TOTAL: begin
							total_q <= mul_prod + 1'b1;
						end
						MUL_PROD: begin
							prod_q  <= mul_prod;
							strip_q <= 1'b0;
							k_q     <= k_adv;
							pidx_q  <= pidx_adv;
							gidx_q  <= gidx_adv;
							wheel_q <= wheel_adv;
						end
						default: begin
							prod_q <= mul_prod;
						end
					endcase
				end
			end
			ST_FOLD: begin
				mul_op_q <= MUL_FINAL;
			end
			default: begin
			end
		endcase
	end

	// output register, parts the sequencer from the result side
	always_ff @(posedge clk) begin
		if (out_load) begin
			sum_q    <= prod_q;
			proper_q <= prod_q - {{(SUM_W - N_W){1'b0}}, n_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, proper_q, sum_q};

`ifndef SYNTHESIS
	// the divider only finishes in its wait state
	a_div_launch: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside its wait state");

	// the multiplier only finishes in its wait state
	a_mul_launch: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL_WAIT))
		else $error("multiplier finished outside its wait state");

	// a zero input goes straight to the result
	a_zero_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (n_in == '0)) |=> ((state_q == ST_DONE) && (prod_q == '0)))
		else $error("zero input did not finish at once");

	// the result register is not reloaded while a result is held unaccepted
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_axis_tready) |=> !$past(out_load))
		else $error("result register overwritten while held");
`endif

endmodule
